// ----- design/lpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and codes for the lsb payload extractor
// Holds the pixel and result word layouts and the result status codes.
// ----------------------------------------------------------------------------
package lpe_pkg;

    // width of the counters, lengths and configuration registers
    localparam int unsigned CountWidth = 32;

    // result status codes
    localparam logic [1:0] STATUS_BYTE      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // configuration register indexes
    localparam logic CFG_PIXEL_COUNT      = 1'b0;
    localparam logic CFG_MAX_OUTPUT_BYTES = 1'b1;

    // one gathered pixel
    typedef struct packed {
        logic       new_message;
        logic [7:0] first_channel;
        logic [7:0] second_channel;
        logic [7:0] third_channel;
    } pixel_word_t;

    // one result word
    typedef struct packed {
        logic [1:0]            status;
        logic [7:0]            data_byte;
        logic [CountWidth-1:0] byte_index;
        logic [CountWidth-1:0] payload_length;
        logic [CountWidth-1:0] trailing_zero_bytes;
        logic                  last;
    } result_word_t;

endpackage

// ----- design/lsb_payload_extractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A pixel word is accepted into the input register, then the step logic
// loads its result into the result register.
// Throughput: one pixel word per cycle while the result register has room;
// the step logic does all three stream bits of a pixel in a single pass.
// Reset: asynchronous, clears the message state and both config registers.
// ----------------------------------------------------------------------------
// lsb_payload_extractor_core: lsb hidden payload extractor
// Reads a length header and payload bytes from the low bits of gathered
// pixels, one pixel word per cycle while the result register has room.
// ----------------------------------------------------------------------------
module lsb_payload_extractor_core #(
    parameter int unsigned LENGTH_FIELD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [lpe_pkg::CountWidth-1:0]      cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  lpe_pkg::pixel_word_t                pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lpe_pkg::result_word_t               result
);

    logic [lpe_pkg::CountWidth-1:0] pixel_count_reg;
    logic [lpe_pkg::CountWidth-1:0] max_bytes_reg;
    logic                           held_valid;
    lpe_pkg::pixel_word_t           held_word;
    logic                           step_valid;
    lpe_pkg::result_word_t          step_word;
    logic                           out_room;
    logic                           take;
    logic                           load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= '0;
            max_bytes_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lpe_pkg::CFG_PIXEL_COUNT:      pixel_count_reg <= cfg_data;
                lpe_pkg::CFG_MAX_OUTPUT_BYTES: max_bytes_reg   <= cfg_data;
                default:                       pixel_count_reg <= pixel_count_reg;
            endcase
        end
    end

    // held pixel moves on unless its result has nowhere to go
    assign take = held_valid && (!step_valid || out_room);
    assign load = take && step_valid;

    lpe_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .take        (take),
        .held_valid  (held_valid),
        .held_word   (held_word)
    );

    lpe_step #(
        .LENGTH_FIELD_BITS (LENGTH_FIELD_BITS)
    ) u_step (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (held_valid),
        .item             (held_word),
        .take             (take),
        .pixel_count      (pixel_count_reg),
        .max_output_bytes (max_bytes_reg),
        .res_valid        (step_valid),
        .res              (step_word)
    );

    lpe_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_word    (step_word),
        .room         (out_room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !(load && result_valid && !result_ready))
        else $error("result register overwritten");

    // truncated header carries no length and ends the message
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == lpe_pkg::STATUS_TRUNCATED)) |->
        (result.last && (result.payload_length == '0)))
        else $error("truncated result malformed");

    // empty payload result ends the message
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == lpe_pkg::STATUS_EMPTY)) |-> result.last)
        else $error("empty payload result without last");

    // a held pixel with a result blocked by a full output stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && step_valid && !out_room) |=> held_valid)
        else $error("blocked pixel dropped");

endmodule

// ----- design/lpe_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_in_stage: pixel input register
// Captures one pixel word a cycle and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module lpe_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  lpe_pkg::pixel_word_t pixel,
    input  logic                 take,
    output logic                 held_valid,
    output lpe_pkg::pixel_word_t held_word
);

    logic                 valid_reg;
    logic                 valid_next;
    lpe_pkg::pixel_word_t word_reg;

    // room when empty or when the held word leaves this cycle
    assign pixel_ready = !valid_reg || take;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (pixel_ready)
        begin
            valid_next = pixel_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (pixel_ready && pixel_valid)
        begin
            word_reg <= pixel;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

// ----- design/lpe_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_step: per-pixel extraction step
// Holds the message state, consumes the three low bits of one pixel and
// forms at most one result word.
// ----------------------------------------------------------------------------
module lpe_step #(
    parameter int unsigned LENGTH_FIELD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  lpe_pkg::pixel_word_t                item,
    input  logic                                take,
    input  logic [lpe_pkg::CountWidth-1:0]      pixel_count,
    input  logic [lpe_pkg::CountWidth-1:0]      max_output_bytes,
    output logic                                res_valid,
    output lpe_pkg::result_word_t               res
);

    localparam int unsigned HbWidth = $clog2(LENGTH_FIELD_BITS + 1);
    localparam int unsigned CW      = lpe_pkg::CountWidth;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_FLUSH   = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    phase_t              phase_reg,    phase_next;
    logic [HbWidth-1:0]  hbits_reg,    hbits_next;
    logic [CW-1:0]       length_reg,   length_next;
    logic [7:0]          assembly_reg, assembly_next;
    logic [2:0]          bitcnt_reg,   bitcnt_next;
    logic [CW-1:0]       emitted_reg,  emitted_next;
    logic [CW-1:0]       seen_reg,     seen_next;

    // one pass over the three stream bits of the pixel
    always_comb
    begin
        logic [2:0]            bits;
        logic                  stop;
        logic                  have;
        logic                  last_byte;
        lpe_pkg::result_word_t word;
        logic                  word_valid;

        phase_next    = phase_reg;
        hbits_next    = hbits_reg;
        length_next   = length_reg;
        assembly_next = assembly_reg;
        bitcnt_next   = bitcnt_reg;
        emitted_next  = emitted_reg;
        seen_next     = seen_reg;
        stop          = 1'b0;
        have          = 1'b0;
        last_byte     = 1'b0;
        word          = '0;
        word_valid    = 1'b0;
        bits          = {item.third_channel[0], item.second_channel[0],
                         item.first_channel[0]};

        // new message clears everything before the pixel is used
        if (item.new_message)
        begin
            phase_next    = PH_HEADER;
            hbits_next    = '0;
            length_next   = '0;
            assembly_next = '0;
            bitcnt_next   = '0;
            emitted_next  = '0;
            seen_next     = '0;
        end

        case (phase_next)
            PH_DONE:
            begin
                word_valid = 1'b0;
            end
            PH_FLUSH:
            begin
                word.status              = lpe_pkg::STATUS_BYTE;
                word.data_byte           = assembly_next;
                word.byte_index          = emitted_next;
                word.payload_length      = length_next;
                word.trailing_zero_bytes = length_next - emitted_next - CW'(1);
                word.last                = 1'b1;
                word_valid               = 1'b1;
                phase_next               = PH_DONE;
            end
            PH_HEADER, PH_PAYLOAD:
            begin
                if (seen_next >= pixel_count)
                begin
                    // no pixel left: truncated header or exhaustion
                    if (phase_next == PH_HEADER)
                    begin
                        word.status = lpe_pkg::STATUS_TRUNCATED;
                        word.last   = 1'b1;
                    end
                    else
                    begin
                        word.status              = lpe_pkg::STATUS_BYTE;
                        word.data_byte           = assembly_next;
                        word.byte_index          = emitted_next;
                        word.payload_length      = length_next;
                        word.trailing_zero_bytes = length_next - emitted_next - CW'(1);
                        word.last                = 1'b1;
                    end
                    word_valid = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    seen_next = seen_next + CW'(1);
                    for (int c = 0; c < 3; c++)
                    begin
                        if (!stop)
                        begin
                            case (phase_next)
                                PH_HEADER:
                                begin
                                    length_next = length_next | (CW'(bits[c]) << hbits_next);
                                    hbits_next  = hbits_next + HbWidth'(1);
                                    if (hbits_next == HbWidth'(LENGTH_FIELD_BITS))
                                    begin
                                        if (length_next > max_output_bytes)
                                        begin
                                            length_next = max_output_bytes;
                                        end
                                        if (length_next == '0)
                                        begin
                                            word            = '0;
                                            word.status     = lpe_pkg::STATUS_EMPTY;
                                            word.last       = 1'b1;
                                            word_valid      = 1'b1;
                                            phase_next      = PH_DONE;
                                            stop            = 1'b1;
                                        end
                                        else
                                        begin
                                            phase_next = PH_PAYLOAD;
                                        end
                                    end
                                end
                                PH_PAYLOAD:
                                begin
                                    assembly_next[bitcnt_next] = bits[c];
                                    if (bitcnt_next == 3'd7)
                                    begin
                                        last_byte = (emitted_next + CW'(1) == length_next);
                                        word.status              = lpe_pkg::STATUS_BYTE;
                                        word.data_byte           = assembly_next;
                                        word.byte_index          = emitted_next;
                                        word.payload_length      = length_next;
                                        word.trailing_zero_bytes = '0;
                                        word.last                = last_byte;
                                        word_valid               = 1'b1;
                                        have                     = 1'b1;
                                        emitted_next  = emitted_next + CW'(1);
                                        assembly_next = '0;
                                        bitcnt_next   = '0;
                                        if (last_byte)
                                        begin
                                            phase_next = PH_DONE;
                                            stop       = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        bitcnt_next = bitcnt_next + 3'd1;
                                    end
                                end
                                default:
                                begin
                                    stop = 1'b1;
                                end
                            endcase
                        end
                    end

                    // pixels ran out on this one
                    if (!stop && (seen_next >= pixel_count))
                    begin
                        if (phase_next == PH_HEADER)
                        begin
                            word        = '0;
                            word.status = lpe_pkg::STATUS_TRUNCATED;
                            word.last   = 1'b1;
                            word_valid  = 1'b1;
                            phase_next  = PH_DONE;
                        end
                        else if (phase_next == PH_PAYLOAD)
                        begin
                            if (have)
                            begin
                                phase_next = PH_FLUSH;
                            end
                            else
                            begin
                                word.status              = lpe_pkg::STATUS_BYTE;
                                word.data_byte           = assembly_next;
                                word.byte_index          = emitted_next;
                                word.payload_length      = length_next;
                                word.trailing_zero_bytes =
                                    length_next - emitted_next - CW'(1);
                                word.last                = 1'b1;
                                word_valid               = 1'b1;
                                phase_next               = PH_DONE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        res       = word;
        res_valid = item_valid && word_valid;
    end

    // message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hbits_reg    <= '0;
            length_reg   <= '0;
            assembly_reg <= '0;
            bitcnt_reg   <= '0;
            emitted_reg  <= '0;
            seen_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            hbits_reg    <= hbits_next;
            length_reg   <= length_next;
            assembly_reg <= assembly_next;
            bitcnt_reg   <= bitcnt_next;
            emitted_reg  <= emitted_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

// ----- design/lpe_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_out_stage: result output register
// Holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module lpe_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  lpe_pkg::result_word_t load_word,
    output logic                  room,
    output logic                  result_valid,
    input  logic                  result_ready,
    output lpe_pkg::result_word_t result
);

    logic                  valid_reg;
    logic                  valid_next;
    lpe_pkg::result_word_t word_reg;

    // free when empty or when the held word is taken this cycle
    assign room = !valid_reg || result_ready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule
